@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL (included by ihi_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that an expression holds at every clock edge out of reset
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another in the same cycle
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/ihi_pkg.sv @@
package ihi_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int POS_W      = 18;
    localparam int MAG_W      = 8;
    localparam int MEM_W      = 2 * POS_W + MAG_W;
    localparam int SQ_W       = 2 * POS_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int LIM_W      = 28;
    localparam int DEN_W      = LIM_W + 1;
    localparam int W_W        = 41;
    localparam int SW_W       = W_W + CNT_W - 1;
    localparam int SWL_W      = SW_W + MAG_W;
    localparam int LVL_W      = 9;
    localparam int LVL_MIN    = 200;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1,
        REG_RADIUS     = 2'd2,
        REG_SMOOTHING  = 2'd3
    } reg_idx_e;

    typedef struct packed {
        logic [12:0] map_width;
        logic [12:0] map_height;
        logic [9:0]  radius;
        logic [15:0] smoothing;
    } cfg_t;

    typedef struct packed {
        cmd_e                    op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [MAG_W-1:0]        mag;
    } item_t;

endpackage

@@ hdl/ihi_front.sv @@
module ihi_front
    import ihi_pkg::*;
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [8:0]       level,
    input  cfg_t                    cfg,
    output logic                    push_valid,
    input  logic                    push_ready,
    output item_t                   push_item
);

    logic signed [19:0] lo_bound;
    logic signed [19:0] hi_x;
    logic signed [19:0] hi_y;
    logic signed [19:0] px_ext;
    logic signed [19:0] py_ext;
    logic               in_window;
    logic               keep;
    logic signed [8:0]  lvl_clamped;

    // Bounds of the map grown by the radius, in 1/16 pixel
    assign lo_bound  = -$signed({6'd0, cfg.radius, 4'd0});
    assign hi_x      = $signed({2'd0, ({1'b0, cfg.map_width} + {4'd0, cfg.radius}), 4'd0});
    assign hi_y      = $signed({2'd0, ({1'b0, cfg.map_height} + {4'd0, cfg.radius}), 4'd0});
    assign px_ext    = 20'(pos_x);
    assign py_ext    = 20'(pos_y);
    assign in_window = (px_ext >= lo_bound) && (px_ext <= hi_x) &&
                       (py_ext >= lo_bound) && (py_ext <= hi_y);

    // Clamp the level into the stored range
    always_comb
    begin
        if (level > 9'sd0)
            lvl_clamped = 9'sd0;
        else if (level < -9'sd200)
            lvl_clamped = -9'sd200;
        else
            lvl_clamped = level;
    end

    // Classify the request: drop unused codes and adds outside the bounds
    always_comb
    begin
        unique case (req_type)
            CMD_CLEAR: keep = 1'b1;
            CMD_ADD:   keep = in_window;
            CMD_QUERY: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign in_ready      = push_ready;
    assign push_valid    = in_valid && keep;
    assign push_item.op  = cmd_e'(req_type);
    assign push_item.x   = pos_x;
    assign push_item.y   = pos_y;
    assign push_item.mag = MAG_W'(-lvl_clamped);

endmodule

@@ hdl/ihi_queue.sv @@
module ihi_queue
    import ihi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

@@ hdl/ihi_back.sv @@
`include "assert_macros.svh"
module ihi_back
    import ihi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  item_t                   pop_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    has_value,
    output logic signed [LVL_W-1:0] interpolated_level
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_READ = 9'b000000010,
        S_SQ   = 9'b000000100,
        S_CMP  = 9'b000001000,
        S_WDIV = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_ACC  = 9'b001000000,
        S_FDIV = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [MEM_W-1:0]        mem [MAX_POINTS];
    logic [MEM_W-1:0]        rd_data_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic signed [POS_W-1:0] qx_reg, qx_next;
    logic signed [POS_W-1:0] qy_reg, qy_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic [SQ_W-1:0]         sqx_reg, sqx_next;
    logic [SQ_W-1:0]         sqy_reg, sqy_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W:0]          rem_reg, rem_next;
    logic [W_W-1:0]          w_reg, w_next;
    logic [5:0]              step_reg, step_next;
    logic [W_W+MAG_W-1:0]    wl_reg, wl_next;
    logic [SW_W-1:0]         sum_w_reg, sum_w_next;
    logic [SWL_W-1:0]        sum_wl_reg, sum_wl_next;
    logic                    hits_reg, hits_next;
    logic [SWL_W-1:0]        frem_reg, frem_next;
    logic [SWL_W-1:0]        fdiv_reg, fdiv_next;
    logic [MAG_W-1:0]        quot_reg, quot_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    has_reg, has_next;
    logic signed [LVL_W-1:0] lvl_reg, lvl_next;

    logic                    wr_en;
    logic signed [POS_W-1:0] pt_x;
    logic signed [POS_W-1:0] pt_y;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic [POS_W-1:0]        ax;
    logic [POS_W-1:0]        ay;
    logic [D2_W-1:0]         d2;
    logic [DEN_W-1:0]        den_raw;
    logic [DEN_W:0]          rem_sh;
    logic                    last_pt;
    logic [13:0]             r16;

    assign pt_x    = rd_data_reg[MEM_W-1 -: POS_W];
    assign pt_y    = rd_data_reg[MAG_W +: POS_W];
    assign dx      = 19'(qx_reg) - 19'(pt_x);
    assign dy      = 19'(qy_reg) - 19'(pt_y);
    assign ax      = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ay      = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    assign d2      = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign den_raw = DEN_W'(d2[LIM_W-1:0]) + DEN_W'(cfg.smoothing);
    assign rem_sh  = {rem_reg[DEN_W-1:0], (step_reg == 6'd0)};
    assign last_pt = (idx_reg + 1'b1 == count_reg);
    assign r16     = {cfg.radius, 4'd0};
    assign wr_en   = (state_reg == S_IDLE) && pop_valid && (pop_item.op == CMD_ADD) &&
                     (count_reg < CNT_W'(MAX_POINTS));
    assign pop_ready = (state_reg == S_IDLE);

    // Point table: write on add, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[ADDR_W-1:0]] <= {pop_item.x, pop_item.y, pop_item.mag};
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    // Sequence commands and the per-point walk
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        lim_next       = lim_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        w_next         = w_reg;
        step_next      = step_reg;
        wl_next        = wl_reg;
        sum_w_next     = sum_w_reg;
        sum_wl_next    = sum_wl_reg;
        hits_next      = hits_reg;
        frem_next      = frem_reg;
        fdiv_next      = fdiv_reg;
        quot_next      = quot_reg;
        has_next       = has_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_item.op)
                        CMD_CLEAR: count_next = '0;
                        CMD_ADD:
                        begin
                            if (wr_en)
                                count_next = count_reg + 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            qx_next     = pop_item.x;
                            qy_next     = pop_item.y;
                            lim_next    = r16 * r16;
                            idx_next    = '0;
                            sum_w_next  = '0;
                            sum_wl_next = '0;
                            hits_next   = 1'b0;
                            state_next  = (count_reg == '0) ? S_OUT : S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: state_next = S_SQ;
            S_SQ:
            begin
                sqx_next   = ax * ax;
                sqy_next   = ay * ay;
                mag_next   = rd_data_reg[MAG_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (d2 > D2_W'(lim_reg))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_pt ? S_FDIV : S_READ;
                end
                else
                begin
                    den_next   = (den_raw == '0) ? DEN_W'(1) : den_raw;
                    rem_next   = '0;
                    w_next     = '0;
                    step_next  = '0;
                    state_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                // One quotient bit of 2^40 / den per cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    w_next   = {w_reg[W_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    w_next   = {w_reg[W_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 6'(W_W - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                wl_next    = w_reg * mag_reg;
                sum_w_next = sum_w_reg + SW_W'(w_reg);
                hits_next  = 1'b1;
                step_next  = '0;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_wl_next = sum_wl_reg + SWL_W'(wl_reg);
                idx_next    = idx_reg + 1'b1;
                state_next  = last_pt ? S_FDIV : S_READ;
            end
            S_FDIV:
            begin
                // Mean is below 256: eight restoring steps on a shifted divisor
                if (step_reg == 6'd0 || !hits_reg)
                begin
                    frem_next = sum_wl_reg;
                    fdiv_next = SWL_W'(sum_w_reg) << (MAG_W - 1);
                    quot_next = '0;
                    step_next = 6'd1;
                    if (!hits_reg)
                        state_next = S_OUT;
                end
                else
                begin
                    if (frem_reg >= fdiv_reg)
                    begin
                        frem_next = frem_reg - fdiv_reg;
                        quot_next = {quot_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quot_next = {quot_reg[MAG_W-2:0], 1'b0};
                    end
                    fdiv_next = fdiv_reg >> 1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == 6'(MAG_W))
                        state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    has_next       = hits_reg;
                    lvl_next       = hits_reg ? -$signed({1'b0, quot_reg}) : '0;
                    step_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        lim_reg    <= lim_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        mag_reg    <= mag_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        w_reg      <= w_next;
        wl_reg     <= wl_next;
        sum_w_reg  <= sum_w_next;
        sum_wl_reg <= sum_wl_next;
        hits_reg   <= hits_next;
        frem_reg   <= frem_next;
        fdiv_reg   <= fdiv_next;
        quot_reg   <= quot_next;
        has_reg    <= has_next;
        lvl_reg    <= lvl_next;
    end

    assign out_valid          = out_valid_reg;
    assign has_value          = has_reg;
    assign interpolated_level = lvl_reg;

    `CHK_ALWAYS(a_count_max, count_reg <= CNT_W'(MAX_POINTS), "point count past table size")
    `CHK_IMPLIES(a_pop_idle, pop_valid && pop_ready, state_reg == S_IDLE, "pop outside idle")
    `CHK_IMPLIES(a_no_value_zero, out_valid && !has_value, interpolated_level == '0,
        "nonzero level without value")
    `CHK_IMPLIES(a_level_range, out_valid,
        interpolated_level >= -9'sd200 && interpolated_level <= 9'sd0, "level out of range")

endmodule

@@ hdl/idw_heatmap_interpolator_top.sv @@
// Clear and add: each handled in the engine's idle state after leaving the two-beat queue.
// Query: per point a table read, square and compare; points within the radius add the
// bit-serial reciprocal divider, multiply and accumulate; a final divide forms the mean.
// Result appears in an output register; the next command starts while it waits.
// Reset (rst_n low, asynchronous) empties the table and loads the register defaults;
// the point memory itself is not cleared.
module idw_heatmap_interpolator_top
    import ihi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [8:0]       level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    has_value,
    output logic signed [LVL_W-1:0] interpolated_level
);

    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= 13'd800;
            cfg_reg.map_height <= 13'd600;
            cfg_reg.radius     <= 10'd500;
            cfg_reg.smoothing  <= 16'd1;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_e'(cfg_index))
                REG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_data[12:0];
                REG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data[12:0];
                REG_RADIUS:     cfg_reg.radius     <= cfg_data[9:0];
                REG_SMOOTHING:  cfg_reg.smoothing  <= cfg_data;
                default: ;
            endcase
        end
    end

    ihi_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .level      (level),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ihi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ihi_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_item           (pop_item),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .has_value          (has_value),
        .interpolated_level (interpolated_level)
    );

endmodule

@@ dv/idw_heatmap_interpolator_top_tb.sv @@
module idw_heatmap_interpolator_top_tb;
    import ihi_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 80000;
    localparam int SETTLE_CYCLES = 60;
    localparam longint POS_MAX = 131071;
    localparam longint POS_MIN = -131072;

    typedef struct {
        logic [1:0]        op;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [8:0]  lvl;
    } req_t;

    typedef struct {
        logic              valid;
        logic signed [8:0] lvl;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type = '0;
    logic signed [17:0] pos_x = '0;
    logic signed [17:0] pos_y = '0;
    logic signed [8:0]  level = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              has_value;
    logic signed [8:0]  interpolated_level;

    idw_heatmap_interpolator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .level(level),
        .out_valid(out_valid), .out_ready(out_ready),
        .has_value(has_value), .interpolated_level(interpolated_level)
    );

    // shadow of the block: registers and point table
    longint  map_w, map_h, radius, smooth;
    longint  tbl_x [MAX_POINTS];
    longint  tbl_y [MAX_POINTS];
    longint  tbl_mag [MAX_POINTS];
    int      n_points;

    req_t    pending_q [$];
    answer_t answer_q [$];
    int      send_idle, recv_idle;
    bit      in_taken;
    bit      beat_seen;
    int      n_errors, n_items, n_queries, n_checked, n_cfg, quiet_cycles;

    // coordinates queued for adds in the current burst, for nearby queries
    longint gen_x [$];
    longint gen_y [$];
    int     n_points_gen;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR t=%0t %s: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    // walk the table the same way the block does and form the weighted mean
    function automatic answer_t interpolate(input longint qx, input longint qy);
        answer_t a;
        longint lim, dx, dy, d2, den, w, sum_w, sum_wl, mag;
        int hits;
        lim = (radius * 16) * (radius * 16);
        sum_w = 0;
        sum_wl = 0;
        hits = 0;
        for (int i = 0; i < n_points; i++)
        begin
            dx = qx - tbl_x[i];
            dy = qy - tbl_y[i];
            d2 = dx * dx + dy * dy;
            if (d2 > lim)
                continue;
            den = d2 + smooth;
            if (den == 0)
                den = 1;
            w = (64'sd1 <<< 40) / den;
            sum_w += w;
            sum_wl += w * tbl_mag[i];
            hits++;
        end
        if (hits != 0 && sum_w != 0)
        begin
            mag = sum_wl / sum_w;
            a.valid = 1'b1;
            a.lvl = 9'(-mag);
        end
        else
        begin
            a.valid = 1'b0;
            a.lvl = '0;
        end
        return a;
    endfunction

    // advance the shadow state by one accepted command
    function automatic void apply_command(input req_t r);
        longint r16, lv;
        bit ok;
        r16 = radius * 16;
        case (r.op)
            CMD_CLEAR: n_points = 0;
            CMD_ADD:
            begin
                ok = r.x >= -r16 && r.x <= map_w * 16 + r16 &&
                     r.y >= -r16 && r.y <= map_h * 16 + r16;
                if (ok && n_points < MAX_POINTS)
                begin
                    lv = r.lvl;
                    if (lv > 0) lv = 0;
                    if (lv < -LVL_MIN) lv = -LVL_MIN;
                    tbl_x[n_points] = r.x;
                    tbl_y[n_points] = r.y;
                    tbl_mag[n_points] = -lv;
                    n_points++;
                end
            end
            CMD_QUERY:
            begin
                answer_q.insert(answer_q.size(), interpolate(r.x, r.y));
                n_queries++;
            end
            default: ;
        endcase
    endfunction

    // drive input beats at the falling edge
    always @(negedge clk)
    begin
        if (!(in_valid && !in_taken))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                req_t r;
                r = pending_q.pop_front();
                in_valid <= 1'b1;
                req_type <= r.op;
                pos_x <= r.x;
                pos_y <= r.y;
                level <= r.lvl;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // sample beats at the rising edge: predict, check, watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            beat_seen = 1'b0;
            if (in_valid && in_ready)
            begin
                req_t r;
                r.op = req_type;
                r.x = pos_x;
                r.y = pos_y;
                r.lvl = level;
                apply_command(r);
                in_taken = 1'b1;
                n_items++;
                beat_seen = 1'b1;
            end
            if (cfg_valid && cfg_ready)
                beat_seen = 1'b1;
            if (out_valid && out_ready)
            begin
                beat_seen = 1'b1;
                if (answer_q.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 1, 0);
                end
                else
                begin
                    answer_t a;
                    a = answer_q.pop_front();
                    n_checked++;
                    if (has_value !== a.valid)
                        report_mismatch("has_value", has_value, a.valid);
                    if (interpolated_level !== a.lvl)
                        report_mismatch("interpolated_level", interpolated_level, a.lvl);
                end
            end
            quiet_cycles <= beat_seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ERROR watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("idw_heatmap_interpolator_top regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_e idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MAP_WIDTH:  map_w = data & 16'h1FFF;
            REG_MAP_HEIGHT: map_h = data & 16'h1FFF;
            REG_RADIUS:     radius = data & 16'h03FF;
            default:        smooth = data;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_map(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] r, input logic [15:0] s);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_RADIUS, r);
        write_reg(REG_SMOOTHING, s);
    endtask

    // hold until every queued beat is in and every result is out
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_req(input logic [1:0] op, input longint x,
                                     input longint y, input longint lv);
        req_t r;
        r.op = op;
        r.x = 18'(x);
        r.y = 18'(y);
        r.lvl = 9'(lv);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // coordinate: mostly inside the acceptance window, some on or just past its edges, some anywhere
    function automatic longint pick_pos(input longint span);
        longint lo, hi;
        lo = -radius * 16;
        hi = (span + radius) * 16;
        if (hi > POS_MAX) hi = POS_MAX;
        case ($urandom_range(11))
            0: return longint'($signed(18'($urandom)));
            1: return lo - $urandom_range(1);
            2: return hi + $urandom_range(1);
            3: return $urandom_range(1) ? POS_MAX : POS_MIN;
            default: return lo + longint'($urandom_range(32'(hi - lo)));
        endcase
    endfunction

    function automatic longint pick_level();
        if ($urandom_range(7) == 0)
            return longint'($signed(9'($urandom)));
        return -longint'($urandom_range(LVL_MIN));
    endfunction

    // query near a stored point, on it, or anywhere in the window
    function automatic void push_query();
        int k;
        longint off;
        if (n_points_gen == 0 || $urandom_range(3) == 0)
        begin
            push_req(CMD_QUERY, pick_pos(map_w), pick_pos(map_h), pick_level());
            return;
        end
        k = $urandom_range(n_points_gen - 1);
        off = $urandom_range(2) == 0 ? 0 : radius * 16 + 1;
        push_req(CMD_QUERY, gen_x[k] + $signed($urandom_range(32'(2 * off))) - off,
                 gen_y[k] + $signed($urandom_range(32'(2 * off))) - off, 0);
    endfunction

    function automatic void push_add(input longint x, input longint y);
        push_req(CMD_ADD, x, y, pick_level());
        gen_x.insert(gen_x.size(), x);
        gen_y.insert(gen_y.size(), y);
        n_points_gen = gen_x.size();
    endfunction

    // bursts of clear, adds and queries with some noise between them
    task automatic random_bursts(input int count);
        int n_adds;
        while (count > 0)
        begin
            gen_x.delete();
            gen_y.delete();
            n_points_gen = 0;
            if ($urandom_range(3) != 0)
            begin
                push_req(CMD_CLEAR, $urandom, $urandom, $urandom);
                count--;
            end
            n_adds = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
            repeat (n_adds)
                push_add(pick_pos(map_w), pick_pos(map_h));
            count -= n_adds;
            repeat ($urandom_range(1, 4))
            begin
                push_query();
                count--;
            end
            if ($urandom_range(4) == 0)
            begin
                push_req(CMD_UNUSED, $urandom, $urandom, $urandom);
                count--;
            end
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase)
            0: begin send_idle = 23; recv_idle = 57; end
            1: begin send_idle = 57; recv_idle = 23; end
            default: begin send_idle = 0; recv_idle = 0; end
        endcase
    endtask

    initial
    begin
        map_w = 800;
        map_h = 600;
        radius = 500;
        smooth = 1;
        n_points = 0;
        in_taken = 1'b0;
        set_idling(0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: bounds, clamps, empty table, unused code, clear
        set_map(16'd800, 16'd600, 16'd500, 16'd1);
        push_req(CMD_QUERY, 0, 0, 0);
        push_req(CMD_ADD, -8000, -8000, 0);
        push_req(CMD_ADD, -8001, 0, -50);
        push_req(CMD_ADD, 0, -8001, -50);
        push_req(CMD_ADD, 20800, 17600, -200);
        push_req(CMD_ADD, 20801, 100, -10);
        push_req(CMD_ADD, 100, 17601, -10);
        push_req(CMD_ADD, 400, 400, 255);
        push_req(CMD_ADD, 800, 800, -256);
        push_req(CMD_ADD, POS_MAX, POS_MIN, -1);
        push_req(CMD_QUERY, -8000, -8000, 0);
        push_req(CMD_QUERY, 600, 600, 0);
        push_req(CMD_QUERY, POS_MAX, POS_MAX, -256);
        push_req(CMD_QUERY, POS_MIN, POS_MIN, 255);
        push_req(CMD_UNUSED, 0, 0, 0);
        push_req(CMD_QUERY, 20800, 17600, 0);
        push_req(CMD_CLEAR, 0, 0, 0);
        push_req(CMD_QUERY, 400, 400, 0);
        drain();

        // tiny map, zero radius, zero smoothing: fill the table past its size, then exact hits only
        set_map(16'd1, 16'd1, 16'd0, 16'd0);
        push_req(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < MAX_POINTS + 4; i++)
            push_req(CMD_ADD, $urandom_range(16), $urandom_range(16), pick_level());
        repeat (4)
            push_req(CMD_QUERY, $urandom_range(16), $urandom_range(16), 0);
        push_req(CMD_QUERY, 17, 0, 0);
        random_bursts(150);
        drain();

        // large map, widest radius, heaviest smoothing
        set_idling(1);
        set_map(16'd4096, 16'd4096, 16'd1023, 16'hFFFF);
        random_bursts(200);
        drain();

        // out-of-range register data is masked
        set_map(16'hFFFF, 16'hE123, 16'hFC20, 16'($urandom_range(1, 255)));
        random_bursts(150);
        drain();

        set_idling(2);
        set_map(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                16'($urandom_range(1, 60)), 16'($urandom_range(1, 65535)));
        random_bursts(200);
        drain();

        $display("covered %0d commands, %0d queries, %0d results checked, %0d register writes",
                 n_items, n_queries, n_checked, n_cfg);
        if (n_errors == 0)
            $display("idw_heatmap_interpolator_top regression: pass");
        else
            $display("idw_heatmap_interpolator_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ihi_pkg.sv
hdl/ihi_front.sv
hdl/ihi_queue.sv
hdl/ihi_back.sv
hdl/idw_heatmap_interpolator_top.sv
dv/idw_heatmap_interpolator_top_tb.sv
